@@ rtl/core/periodic_dwt_analysis_top_macros.svh @@
// Assertion macros shared by the wavelet analysis RTL.
// Included by files that carry concurrent checks.
`ifndef PERIODIC_DWT_ANALYSIS_TOP_MACROS_SVH
`define PERIODIC_DWT_ANALYSIS_TOP_MACROS_SVH
`define PDWT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PDWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/core/pdwt_pkg.sv @@
// Package for the periodic wavelet analysis block.
// Types, constants and helpers; no dependencies.
package pdwt_pkg;
   localparam int MAX_LENGTH_LOG2_DEF = 10;
   localparam int MAX_TAPS_DEF = 8;
   localparam int DATA_W = 32;
   localparam int ACC_W = 56;

   localparam logic [2:0] CSR_LENGTH_LOG2 = 3'd0;
   localparam logic [2:0] CSR_LEVEL_COUNT = 3'd1;
   localparam logic [2:0] CSR_TAP_COUNT   = 3'd2;
   localparam logic [2:0] CSR_LOW_FIRST   = 3'd3;
   localparam logic [2:0] CSR_LOW_SECOND  = 3'd4;
   localparam logic [2:0] CSR_HIGH_FIRST  = 3'd5;
   localparam logic [2:0] CSR_HIGH_SECOND = 3'd6;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] sample_value;
      logic [9:0]  read_index;
   } req_item_type;

   typedef struct packed {
      logic [31:0] coefficient;
      logic        read_error;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ_WAIT, ST_RSP, ST_COPY, ST_LVL_COPY,
      ST_MAC_ADDR, ST_MAC_ACC, ST_MAC_LAST, ST_WRITE_LO, ST_WRITE_HI, ST_LVL_NEXT
   } state_type;

   typedef struct packed {
      logic        clear;
      logic        accumulate;
      logic [15:0] tap;
      logic [31:0] sample;
   } mac_ctrl_type;

   function automatic logic [31:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] q;
      q = (acc + ACC_W'(8192)) >>> 14;
      if (q > ACC_W'(64'sh7FFFFFFF)) return 32'h7FFFFFFF;
      if (q < -ACC_W'(64'sh80000000)) return 32'h80000000;
      return q[31:0];
   endfunction
endpackage

@@ rtl/core/pdwt_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module pdwt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/core/pdwt_mac.sv @@
// Shared multiply-accumulate unit, 32x16 product, 56-bit accumulator.
// Depends on pdwt_pkg.
module pdwt_mac
   import pdwt_pkg::*;
(
   input  logic                       clock,
   input  mac_ctrl_type               ctrl,
   output logic signed [ACC_W-1:0]    acc
);
   logic signed [47:0] prod_ff, prod_in;
   logic               acc_en_ff, clr_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   assign prod_in = $signed(ctrl.sample) * $signed(ctrl.tap);
   always_comb begin
      acc_in = acc_ff;
      if (clr_ff) acc_in = '0;
      else if (acc_en_ff) acc_in = acc_ff + ACC_W'(prod_ff);
   end
   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      acc_en_ff <= ctrl.accumulate;
      clr_ff    <= ctrl.clear;
      acc_ff    <= acc_in;
   end
   assign acc = acc_ff;
endmodule

@@ rtl/core/periodic_dwt_analysis_top.sv @@
// Top level of the periodic wavelet analysis block.
// Depends on pdwt_pkg, pdwt_ram, pdwt_mac and the assertion macros.
// The last load of a signal runs the transform: a copy of the signal, then per level a
// copy and level turnover and, per output pair, filtering on the one shared
// multiply-accumulate (low and high filters take turns on it). Reads go through the
// registered memory port, and the result may be stalled. The block is not ready meanwhile.
`include "periodic_dwt_analysis_top_macros.svh"
module periodic_dwt_analysis_top
   import pdwt_pkg::*;
#(
   parameter int MAX_LENGTH_LOG2 = MAX_LENGTH_LOG2_DEF,
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);
   localparam int AW = MAX_LENGTH_LOG2;
   localparam int DEPTH = 1 << AW;
   localparam int LW = $clog2(MAX_LENGTH_LOG2 + 1);
   localparam int CW = (AW > 10) ? AW + 1 : 11;

   logic [3:0]  len_ff, lvl_ff, taps_ff;
   logic [63:0] lo1_ff, lo2_ff, hi1_ff, hi2_ff;
   logic [AW:0] load_cnt_ff, load_cnt_in;
   logic        done_ff, done_in;
   state_type   state_ff, state_in;
   logic [AW:0] idx_ff, idx_in;     // copy index / output index i
   logic [3:0]  k_ff, k_in;
   logic        hi_ff, hi_in;
   logic [AW:0] m_ff, m_in;
   logic [LW-1:0] lvl_left_ff, lvl_left_in;
   logic [31:0] lo_res_ff, lo_res_in;
   logic [9:0]  rd_idx_ff, rd_idx_in;
   logic        rd_err_ff, rd_err_in;

   logic [LW-1:0] eff_lg, eff_lv;
   logic [3:0]  eff_taps;
   logic [AW:0] n_len;

   always_comb begin
      eff_lg = (len_ff < 4'd1) ? LW'(1) :
               ({1'b0, len_ff} > 5'(MAX_LENGTH_LOG2)) ? LW'(MAX_LENGTH_LOG2) : LW'(len_ff);
      eff_lv = ({1'b0, lvl_ff} > 5'(eff_lg)) ? eff_lg : LW'(lvl_ff);
      eff_taps = (taps_ff < 4'd1) ? 4'd1 : (taps_ff > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : taps_ff;
      n_len = (AW+1)'(1) << eff_lg;
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= 4'd10; lvl_ff <= 4'd1; taps_ff <= 4'd2;
         lo1_ff <= '0; lo2_ff <= '0; hi1_ff <= '0; hi2_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LENGTH_LOG2: len_ff  <= csr_data[3:0];
            CSR_LEVEL_COUNT: lvl_ff  <= csr_data[3:0];
            CSR_TAP_COUNT:   taps_ff <= csr_data[3:0];
            CSR_LOW_FIRST:   lo1_ff  <= csr_data;
            CSR_LOW_SECOND:  lo2_ff  <= csr_data;
            CSR_HIGH_FIRST:  hi1_ff  <= csr_data;
            CSR_HIGH_SECOND: hi2_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   logic          w_we, c_we;
   logic [AW-1:0] w_wa, w_ra, c_wa, c_ra;
   logic [31:0]   w_wd, w_rd, c_wd, c_rd;
   logic          c_we_f;
   logic [AW-1:0] c_wa_f;
   logic [31:0]   c_wd_f;
   pdwt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_work (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(w_ra), .rd_data(w_rd));
   pdwt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_coef (
      .clock(clock), .wr_en(c_we_f), .wr_addr(c_wa_f), .wr_data(c_wd_f),
      .rd_addr(c_ra), .rd_data(c_rd));

   mac_ctrl_type mac_ctrl;
   logic signed [ACC_W-1:0] acc;
   pdwt_mac u_mac (.clock(clock), .ctrl(mac_ctrl), .acc(acc));

   logic [63:0] tw;
   logic [15:0] tap_sel;
   logic [3:0]  k_pipe_ff;
   always_comb begin
      tw = hi_ff ? (k_pipe_ff[2] ? hi2_ff : hi1_ff) : (k_pipe_ff[2] ? lo2_ff : lo1_ff);
      tap_sel = tw[16*k_pipe_ff[1:0] +: 16];
   end

   logic [AW:0] half_m;
   assign half_m = m_ff >> 1;
   logic [AW:0] sidx;
   assign sidx = ((idx_ff << 1) + (AW+1)'(k_ff)) & (m_ff - (AW+1)'(1));

   logic req_acc;
   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_acc) begin
               if (req_item.req_type == REQ_READ) state_in = ST_READ_WAIT;
               else if (((done_ff ? (AW+1)'(0) : load_cnt_ff) + (AW+1)'(1)) >= n_len)
                  state_in = ST_COPY;
            end
         ST_READ_WAIT: state_in = ST_RSP;
         ST_RSP:       if (!rsp_stall) state_in = ST_IDLE;
         ST_COPY:
            if (idx_ff == n_len) state_in = (eff_lv == '0) ? ST_IDLE : ST_LVL_COPY;
         ST_LVL_COPY:  if (idx_ff == m_ff) state_in = ST_MAC_ADDR;
         ST_MAC_ADDR:  state_in = ST_MAC_ACC;
         ST_MAC_ACC:   if (k_ff == eff_taps) state_in = ST_MAC_LAST;
         ST_MAC_LAST:  state_in = hi_ff ? ST_WRITE_HI : ST_WRITE_LO;
         ST_WRITE_LO:  state_in = ST_MAC_ADDR;
         ST_WRITE_HI:
            if (idx_ff + (AW+1)'(1) == half_m) state_in = ST_LVL_NEXT;
            else state_in = ST_MAC_ADDR;
         ST_LVL_NEXT:  state_in = (lvl_left_ff == LW'(1)) ? ST_IDLE : ST_LVL_COPY;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      load_cnt_in = load_cnt_ff; done_in = done_ff; idx_in = idx_ff; k_in = k_ff;
      hi_in = hi_ff; m_in = m_ff; lvl_left_in = lvl_left_ff; lo_res_in = lo_res_ff;
      rd_idx_in = rd_idx_ff; rd_err_in = rd_err_ff;
      w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = '0;
      c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = AW'(rd_idx_ff);
      mac_ctrl = '0;
      case (state_ff)
         ST_IDLE:
            if (req_acc) begin
               if (req_item.req_type == REQ_READ) begin
                  rd_idx_in = req_item.read_index;
                  rd_err_in = !done_ff || (CW'(req_item.read_index) >= CW'(n_len));
               end else begin
                  w_we = 1'b1;
                  w_wa = done_ff ? '0 : load_cnt_ff[AW-1:0];
                  w_wd = 32'(signed'(req_item.sample_value));
                  load_cnt_in = (done_ff ? (AW+1)'(0) : load_cnt_ff) + (AW+1)'(1);
                  done_in = 1'b0;
                  if (load_cnt_in >= n_len) begin
                     load_cnt_in = '0; done_in = 1'b1;
                     idx_in = '0; m_in = n_len; lvl_left_in = eff_lv;
                  end
               end
            end
         ST_COPY: begin
            w_ra = idx_ff[AW-1:0];
            if (idx_ff != '0) begin
               c_we = 1'b1; c_wa = AW'(idx_ff - (AW+1)'(1)); c_wd = w_rd;
            end
            idx_in = (idx_ff == n_len) ? '0 : idx_ff + (AW+1)'(1);
         end
         ST_LVL_COPY: begin
            c_ra = idx_ff[AW-1:0];
            if (idx_ff != '0) begin
               w_we = 1'b1; w_wa = AW'(idx_ff - (AW+1)'(1)); w_wd = c_rd;
            end
            idx_in = (idx_ff == m_ff) ? '0 : idx_ff + (AW+1)'(1);
            k_in = '0; hi_in = 1'b0;
         end
         ST_MAC_ADDR: begin
            w_ra = sidx[AW-1:0]; k_in = k_ff + 4'd1;
            mac_ctrl.clear = 1'b1;
         end
         ST_MAC_ACC: begin
            w_ra = sidx[AW-1:0];
            mac_ctrl.accumulate = 1'b1; mac_ctrl.sample = w_rd; mac_ctrl.tap = tap_sel;
            k_in = k_ff + 4'd1;
         end
         ST_MAC_LAST: k_in = '0;
         ST_WRITE_LO: begin
            lo_res_in = round_sat(acc); hi_in = 1'b1;
         end
         ST_WRITE_HI: begin
            c_we = 1'b1; c_wa = idx_ff[AW-1:0]; c_wd = lo_res_ff;
            lo_res_in = round_sat(acc);
            hi_in = 1'b0; idx_in = idx_ff + (AW+1)'(1);
         end
         ST_LVL_NEXT: begin
            c_we = 1'b1; c_wa = AW'(half_m + idx_ff - (AW+1)'(1)); c_wd = lo_res_ff;
            m_in = half_m; lvl_left_in = lvl_left_ff - LW'(1); idx_in = '0;
         end
         default: ;
      endcase
   end

   // high result of each pair is written during the next pair's ST_MAC_ADDR state; the last pair's at ST_LVL_NEXT
   logic        hi_pend_ff;
   logic [31:0] hi_val_ff;
   logic [AW:0] hi_addr_ff;
   always_ff @(posedge clock) begin
      if (reset) hi_pend_ff <= 1'b0;
      else hi_pend_ff <= (state_ff == ST_WRITE_HI) && (state_in != ST_LVL_NEXT);
      hi_val_ff  <= round_sat(acc);
      hi_addr_ff <= half_m + idx_ff;
   end

   always_comb begin
      c_we_f = c_we; c_wa_f = c_wa; c_wd_f = c_wd;
      if (hi_pend_ff) begin
         c_we_f = 1'b1; c_wa_f = hi_addr_ff[AW-1:0]; c_wd_f = hi_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; load_cnt_ff <= '0; done_ff <= 1'b0;
      end else begin
         state_ff <= state_in; load_cnt_ff <= load_cnt_in; done_ff <= done_in;
      end
      idx_ff <= idx_in; k_ff <= k_in; hi_ff <= hi_in; m_ff <= m_in;
      lvl_left_ff <= lvl_left_in; lo_res_ff <= lo_res_in;
      rd_idx_ff <= rd_idx_in; rd_err_ff <= rd_err_in;
      k_pipe_ff <= k_ff;
   end

   assign rsp_valid = (state_ff == ST_RSP);
   assign rsp_item.coefficient = rd_err_ff ? 32'd0 : c_rd;
   assign rsp_item.read_error = rd_err_ff;

   `PDWT_ASSERT_IMPL(a_stall_busy, clock, reset, state_ff != ST_IDLE, req_stall, "busy not stalled")
   `PDWT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "rsp dropped")
   `PDWT_ASSERT_IMPL(a_no_dual_wr, clock, reset, hi_pend_ff, (state_ff == ST_MAC_ADDR), "coef write clash")
endmodule

@@ bench/tb_periodic_dwt_analysis_top.sv @@
// Self-checking testbench for periodic_dwt_analysis_top: loads signals, runs transforms,
// reads back coefficients and checks them against a built-in wavelet predictor.
// Depends on pdwt_pkg and the block's RTL only.
module tb_periodic_dwt_analysis_top;
   import pdwt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = CSR_LENGTH_LOG2;
   logic [63:0]  csr_data = '0;

   periodic_dwt_analysis_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [3:0]  cfg_length, cfg_levels, cfg_taps;
   logic [63:0] low_first, low_second, high_first, high_second;
   logic [31:0] work_mem [0:1023];
   logic [31:0] coef_mem [0:1023];
   int          load_cnt;
   bit          analysis_done;
   int          busy_cycles;

   rsp_item_type expected_rsp[$];
   int          errors;
   int          items_sent;
   bit          quiet_mode;
   int          hold_cycles;

   function automatic int eff_length();
      if (cfg_length < 1) return 1;
      if (cfg_length > 10) return 10;
      return cfg_length;
   endfunction

   function automatic longint tap_value(logic [63:0] first, logic [63:0] second, int j);
      logic [63:0] w;
      w = (j < 4) ? first : second;
      return longint'($signed(w[16*(j%4) +: 16]));
   endfunction

   function automatic logic [31:0] round_saturate(longint acc);
      longint q;
      q = (acc + 64'sd8192) >>> 14;
      if (q > 64'sd2147483647) return 32'h7FFFFFFF;
      if (q < -64'sd2147483648) return 32'h80000000;
      return q[31:0];
   endfunction

   task automatic run_analysis();
      int lg, n, levels, taps, m, half;
      longint lo, hi, x;
      lg = eff_length();
      n = 1 << lg;
      levels = (cfg_levels > lg) ? lg : cfg_levels;
      taps = (cfg_taps < 1) ? 1 : ((cfg_taps > 8) ? 8 : cfg_taps);
      busy_cycles += n + 1;
      for (int i = 0; i < n; i++) coef_mem[i] = work_mem[i];
      for (int lev = 0; lev < levels; lev++) begin
         m = n >> lev;
         half = m >> 1;
         busy_cycles += m + 2 + half * (2 * taps + 6);
         for (int i = 0; i < m; i++) work_mem[i] = coef_mem[i];
         for (int i = 0; i < half; i++) begin
            lo = 0;
            hi = 0;
            for (int k = 0; k < taps; k++) begin
               x = longint'($signed(work_mem[(2 * i + k) & (m - 1)]));
               lo += x * tap_value(low_first, low_second, k);
               hi += x * tap_value(high_first, high_second, k);
            end
            coef_mem[i] = round_saturate(lo);
            coef_mem[half + i] = round_saturate(hi);
         end
      end
   endtask

   task automatic predict_item(req_item_type it);
      rsp_item_type r;
      int n;
      n = 1 << eff_length();
      if (it.req_type == REQ_LOAD) begin
         if (analysis_done) begin
            analysis_done = 0;
            load_cnt = 0;
         end
         work_mem[load_cnt % 1024] = {{16{it.sample_value[15]}}, it.sample_value};
         load_cnt = (load_cnt + 1) % 2048;
         if (load_cnt >= n) begin
            run_analysis();
            load_cnt = 0;
            analysis_done = 1;
         end
      end else begin
         if (!analysis_done || it.read_index >= n) begin
            r.coefficient = '0;
            r.read_error = 1'b1;
         end else begin
            r.coefficient = coef_mem[it.read_index];
            r.read_error = 1'b0;
         end
         expected_rsp.push_back(r);
      end
   endtask

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result");
         end else begin
            if (rsp_item.coefficient !== expected_rsp[0].coefficient)
               report_mismatch($sformatf("coefficient %h, want %h",
                  rsp_item.coefficient, expected_rsp[0].coefficient));
            if (rsp_item.read_error !== expected_rsp[0].read_error)
               report_mismatch($sformatf("read_error %b, want %b",
                  rsp_item.read_error, expected_rsp[0].read_error));
            void'(expected_rsp.pop_front());
         end
      end
   end

   // result receiver stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= !quiet_mode && ($urandom_range(99) < 12);
      end
   end

   task automatic send_item(req_item_type it);
      @(negedge clock);
      while (!quiet_mode && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_item(it);
   endtask

   task automatic send_load(logic [15:0] v);
      req_item_type it;
      it.req_type = REQ_LOAD;
      it.sample_value = v;
      it.read_index = 10'($urandom);
      send_item(it);
   endtask

   task automatic send_read(logic [9:0] idx);
      req_item_type it;
      it.req_type = REQ_READ;
      it.sample_value = 16'($urandom);
      it.read_index = idx;
      send_item(it);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2 * busy_cycles + 20) @(posedge clock);
      busy_cycles = 0;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LENGTH_LOG2: cfg_length = value[3:0];
         CSR_LEVEL_COUNT: cfg_levels = value[3:0];
         CSR_TAP_COUNT:   cfg_taps = value[3:0];
         CSR_LOW_FIRST:   low_first = value;
         CSR_LOW_SECOND:  low_second = value;
         CSR_HIGH_FIRST:  high_first = value;
         CSR_HIGH_SECOND: high_second = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // clamped length, levels and taps at top; saturating taps; fills every store entry
   task automatic test_full_length();
      send_read(10'd0);
      wait_idle();
      write_reg(CSR_LENGTH_LOG2, 64'd15);
      write_reg(CSR_LEVEL_COUNT, 64'd15);
      write_reg(CSR_TAP_COUNT, 64'd15);
      write_reg(CSR_LOW_FIRST, {4{16'h7FFF}});
      write_reg(CSR_LOW_SECOND, {4{16'h7FFF}});
      write_reg(CSR_HIGH_FIRST, {4{16'h8000}});
      write_reg(CSR_HIGH_SECOND, {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF});
      send_load(16'h7FFF);
      send_read(10'd0);
      for (int i = 1; i < 1024; i++) send_load((i % 3 == 0) ? 16'h8000 : 16'h7FFF);
      send_read(10'd0);
      send_read(10'd1);
      send_read(10'd512);
      send_read(10'd1023);
      wait_idle();
   endtask

   // length below range, zero levels, single tap, load after finish
   task automatic test_small_cases();
      write_reg(CSR_LENGTH_LOG2, 64'd0);
      write_reg(CSR_LEVEL_COUNT, 64'd0);
      write_reg(CSR_TAP_COUNT, 64'd0);
      write_reg(CSR_LOW_FIRST, rand_word());
      write_reg(CSR_HIGH_FIRST, rand_word());
      send_load(16'h8000);
      send_load(16'h7FFF);
      send_read(10'd0);
      send_read(10'd1);
      send_read(10'd2);
      send_read(10'h3FF);
      send_load(16'h0000);
      send_read(10'd0);
      send_load(16'hFFFF);
      send_read(10'd1);
      wait_idle();
      write_reg(CSR_LEVEL_COUNT, 64'd1);
      write_reg(CSR_TAP_COUNT, 64'd8);
      send_load(16'h1234);
      send_load(16'hEDCB);
      send_read(10'd0);
      send_read(10'd1);
      wait_idle();
   endtask

   // length reduced while a signal is partly loaded
   task automatic test_length_change();
      write_reg(CSR_LENGTH_LOG2, 64'd4);
      write_reg(CSR_LEVEL_COUNT, 64'd2);
      for (int i = 0; i < 5; i++) send_load(rand_sample());
      wait_idle();
      write_reg(CSR_LENGTH_LOG2, 64'd2);
      send_load(rand_sample());
      for (int i = 0; i < 5; i++) send_read(10'(i));
      wait_idle();
   endtask

   task automatic test_random();
      int lg, n, reads;
      while (items_sent < 1200) begin
         quiet_mode = ($urandom_range(7) == 0);
         lg = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
         write_reg(CSR_LENGTH_LOG2, 64'(lg));
         write_reg(CSR_LEVEL_COUNT, 64'($urandom_range(0, lg + 1)));
         write_reg(CSR_TAP_COUNT, 64'($urandom_range(0, 15)));
         write_reg(CSR_LOW_FIRST, rand_word());
         write_reg(CSR_LOW_SECOND, rand_word());
         write_reg(CSR_HIGH_FIRST, rand_word());
         write_reg(CSR_HIGH_SECOND, rand_word());
         n = 1 << lg;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) send_read(10'($urandom));
            send_load(rand_sample());
         end
         reads = $urandom_range(4, 24);
         for (int i = 0; i < reads; i++)
            send_read(($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(n - 1)));
         wait_idle();
      end
      quiet_mode = 0;
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      hold_cycles = 400;
      for (int i = 0; i < 30; i++) send_read(10'($urandom));
      wait_idle();
   endtask

   initial begin
      cfg_length = 4'd10;
      cfg_levels = 4'd1;
      cfg_taps = 4'd2;
      low_first = '0;
      low_second = '0;
      high_first = '0;
      high_second = '0;
      load_cnt = 0;
      analysis_done = 0;
      busy_cycles = 0;
      errors = 0;
      items_sent = 0;
      quiet_mode = 0;
      hold_cycles = 0;
      for (int i = 0; i < 1024; i++) begin
         work_mem[i] = '0;
         coef_mem[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (2200) @(posedge clock);
      test_full_length();
      test_small_cases();
      test_length_change();
      test_backpressure();
      test_random();
      wait_idle();
      if (errors == 0)
         $display("tb_periodic_dwt_analysis_top: clean");
      else
         $display("tb_periodic_dwt_analysis_top: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_periodic_dwt_analysis_top: errors");
      $finish;
   end
endmodule
